### sv/tsbs_pkg.sv
// ----------------------------------------------------------------------------
// tsbs_pkg
// Shared types for the two-sphere bounding sphere pipeline.
// ----------------------------------------------------------------------------
package tsbs_pkg;

   // handshake between the top level and a pipelined arithmetic unit
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

### sv/two_sphere_bounding_sphere.sv
// ----------------------------------------------------------------------------
// two_sphere_bounding_sphere
// Smallest sphere enclosing two spheres, signed fixed-point centers.
// ----------------------------------------------------------------------------
// Fully pipelined: one sphere pair is taken every cycle while the output is not
// stalled. The pipeline holds a square root, one root bit per stage, and a
// center divider, one quotient bit per stage. The whole pipeline holds while a
// result waits on rsp_tready. When one sphere contains the other (exact test on
// squared lengths) the larger is returned with enclosed set; on equal radii the
// second sphere wins. Otherwise the radius is (r1+r2+d)/2 rounded down, the
// center offset is truncated toward zero, and clamped results set saturated.
module two_sphere_bounding_sphere #(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_x, first_y, first_z, first_radius,
   // second_x, second_y, second_z, second_radius
   input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x, out_y, out_z, out_radius
   output logic [((4*COORD_WIDTH-1+7)/8)*8-1:0] rsp_tdata,
   // enclosed, saturated
   output logic [1:0] rsp_tuser
);

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int RWID = CW - 1;
   localparam int RTW  = DW + 1;
   localparam int SQW  = 2 * RTW;
   localparam int RFW  = RTW + 1;
   localparam int FW   = CW + 2;
   localparam int RSPW = ((4*CW-1+7)/8)*8;
   localparam int SB1  = 6*CW + 3*DW + 3 + 2*RWID + 2;
   localparam int SB2  = 6*CW + 3 + RFW + 2 + 2*RWID;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 1: unpack, center differences
   logic                   s1_valid_ff;
   logic signed [CW-1:0]   s1_c1_ff [3];
   logic signed [CW-1:0]   s1_c2_ff [3];
   logic signed [DW-1:0]   s1_dc_ff [3];
   logic [RWID-1:0]        s1_r1_ff, s1_r2_ff, s1_rdiff_ff;
   logic                   s1_pick_ff;

   logic [CW-1:0]   in_c1 [3];
   logic [CW-1:0]   in_c2 [3];
   logic [RWID-1:0] in_r1, in_r2;

   for (genvar k = 0; k < 3; k++) begin : g_unpack
      assign in_c1[k] = req_tdata[k*CW +: CW];
      assign in_c2[k] = req_tdata[4*CW-1 + k*CW +: CW];
   end
   assign in_r1 = req_tdata[3*CW +: RWID];
   assign in_r2 = req_tdata[7*CW-1 +: RWID];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            s1_c1_ff[k] <= in_c1[k];
            s1_c2_ff[k] <= in_c2[k];
            s1_dc_ff[k] <= {in_c2[k][CW-1], in_c2[k]} - {in_c1[k][CW-1], in_c1[k]};
         end
         s1_r1_ff    <= in_r1;
         s1_r2_ff    <= in_r2;
         s1_rdiff_ff <= (in_r1 > in_r2) ? (in_r1 - in_r2) : (in_r2 - in_r1);
         s1_pick_ff  <= (in_r1 > in_r2);
      end
   end

   // stage 2: magnitudes and squares
   logic                 s2_valid_ff;
   logic signed [CW-1:0] s2_c1_ff [3];
   logic signed [CW-1:0] s2_c2_ff [3];
   logic [DW-1:0]        s2_abs_ff [3];
   logic                 s2_neg_ff [3];
   logic [2*DW-1:0]      s2_sq_ff [3];
   logic [2*RWID-1:0]    s2_dsq_ff;
   logic [RWID-1:0]      s2_r1_ff, s2_r2_ff;
   logic                 s2_pick_ff;

   logic [DW-1:0] abs_dc [3];
   for (genvar k = 0; k < 3; k++) begin : g_abs
      assign abs_dc[k] = s1_dc_ff[k][DW-1] ? (DW'(0) - s1_dc_ff[k]) : s1_dc_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            s2_c1_ff[k]  <= s1_c1_ff[k];
            s2_c2_ff[k]  <= s1_c2_ff[k];
            s2_abs_ff[k] <= abs_dc[k];
            s2_neg_ff[k] <= s1_dc_ff[k][DW-1];
            s2_sq_ff[k]  <= abs_dc[k] * abs_dc[k];
         end
         s2_dsq_ff  <= s1_rdiff_ff * s1_rdiff_ff;
         s2_r1_ff   <= s1_r1_ff;
         s2_r2_ff   <= s1_r2_ff;
         s2_pick_ff <= s1_pick_ff;
      end
   end

   // stage 3: squared distance and containment test
   logic           s3_valid_ff;
   logic [SQW-1:0] s3_s_ff;
   logic [SB1-1:0] s3_side_ff;

   logic [SQW-1:0] dist_sq;
   assign dist_sq = SQW'(s2_sq_ff[0]) + SQW'(s2_sq_ff[1]) + SQW'(s2_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_s_ff    <= dist_sq;
         s3_side_ff <= {s2_c1_ff[0], s2_c1_ff[1], s2_c1_ff[2],
                        s2_c2_ff[0], s2_c2_ff[1], s2_c2_ff[2],
                        s2_abs_ff[0], s2_abs_ff[1], s2_abs_ff[2],
                        s2_neg_ff[0], s2_neg_ff[1], s2_neg_ff[2],
                        s2_r1_ff, s2_r2_ff, s2_pick_ff,
                        (dist_sq <= SQW'(s2_dsq_ff))};
      end
   end

   // square root
   tsbs_pkg::pipe_ctl_type sqrt_ctl;
   logic                   sq_valid;
   logic [RTW-1:0]         sq_root;
   logic [SB1-1:0]         sq_side;

   assign sqrt_ctl.advance = advance;
   assign sqrt_ctl.valid   = s3_valid_ff;

   tsbs_sqrt #(.RTW(RTW), .SBW(SB1)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sqrt_ctl),
      .radicand  (s3_s_ff),
      .side_in   (s3_side_ff),
      .valid_out (sq_valid),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   logic [CW-1:0]   q_c1 [3];
   logic [CW-1:0]   q_c2 [3];
   logic [DW-1:0]   q_abs [3];
   logic            q_neg [3];
   logic [RWID-1:0] q_r1, q_r2;
   logic            q_pick, q_cont;

   assign {q_c1[0], q_c1[1], q_c1[2], q_c2[0], q_c2[1], q_c2[2],
           q_abs[0], q_abs[1], q_abs[2], q_neg[0], q_neg[1], q_neg[2],
           q_r1, q_r2, q_pick, q_cont} = sq_side;

   // stage 4: radius and offset scale
   logic            s4_valid_ff;
   logic [RFW-1:0]  s4_rfull_ff;
   logic [RTW-1:0]  s4_t_ff;
   logic [RTW-1:0]  s4_d_ff;
   logic [DW-1:0]   s4_abs_ff [3];
   logic [SB2-1:0]  s4_side_ff;

   logic [RFW:0]   rad_sum;
   logic [RFW-1:0] rfull;
   assign rad_sum = (RFW+1)'(q_r1) + (RFW+1)'(q_r2) + (RFW+1)'(sq_root);
   assign rfull   = rad_sum[RFW:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_rfull_ff <= rfull;
         s4_t_ff     <= RTW'(rfull - RFW'(q_r1));
         s4_d_ff     <= sq_root;
         for (int k = 0; k < 3; k++) begin
            s4_abs_ff[k] <= q_abs[k];
         end
         s4_side_ff  <= {q_c1[0], q_c1[1], q_c1[2], q_c2[0], q_c2[1], q_c2[2],
                         q_neg[0], q_neg[1], q_neg[2], rfull, q_pick, q_cont,
                         q_r1, q_r2};
      end
   end

   // stage 5: offset numerators
   logic               s5_valid_ff;
   logic [DW+RTW-1:0]  s5_prod_ff [3];
   logic [RTW-1:0]     s5_d_ff;
   logic [SB2-1:0]     s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            s5_prod_ff[k] <= s4_abs_ff[k] * s4_t_ff;
         end
         s5_d_ff    <= s4_d_ff;
         s5_side_ff <= s4_side_ff;
      end
   end

   // divider
   tsbs_pkg::pipe_ctl_type div_ctl;
   logic                   dv_valid;
   logic [DW-1:0]          dv_quot [3];
   logic [SB2-1:0]         dv_side;

   assign div_ctl.advance = advance;
   assign div_ctl.valid   = s5_valid_ff;

   tsbs_div #(.DVW(RTW), .QW(DW), .SBW(SB2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .numer     (s5_prod_ff),
      .divisor   (s5_d_ff),
      .side_in   (s5_side_ff),
      .valid_out (dv_valid),
      .quot_out  (dv_quot),
      .side_out  (dv_side)
   );

   logic [CW-1:0]   f_c1 [3];
   logic [CW-1:0]   f_c2 [3];
   logic            f_neg [3];
   logic [RFW-1:0]  f_rfull;
   logic            f_pick, f_cont;
   logic [RWID-1:0] f_r1, f_r2;

   assign {f_c1[0], f_c1[1], f_c1[2], f_c2[0], f_c2[1], f_c2[2],
           f_neg[0], f_neg[1], f_neg[2], f_rfull, f_pick, f_cont,
           f_r1, f_r2} = dv_side;

   // final stage: center, clamping, selection
   logic signed [FW-1:0] cen [3];
   logic signed [FW-1:0] cmax, cmin;
   logic [CW-1:0]        cen_sat [3];
   logic [2:0]           cen_clip;
   logic                 rad_clip;
   logic [RWID-1:0]      rad_sat;

   assign cmax = FW'({1'b0, {RWID{1'b1}}});
   assign cmin = ~cmax;

   for (genvar k = 0; k < 3; k++) begin : g_cen
      logic signed [FW-1:0] base;
      logic signed [FW-1:0] ofs;
      assign base = {{2{f_c1[k][CW-1]}}, f_c1[k]};
      assign ofs  = {1'b0, dv_quot[k]};
      assign cen[k] = f_neg[k] ? (base - ofs) : (base + ofs);
      assign cen_clip[k] = (cen[k] > cmax) || (cen[k] < cmin);
      assign cen_sat[k]  = (cen[k] > cmax) ? cmax[CW-1:0] :
                           (cen[k] < cmin) ? cmin[CW-1:0] : cen[k][CW-1:0];
   end

   assign rad_clip = |f_rfull[RFW-1:RWID];
   assign rad_sat  = rad_clip ? {RWID{1'b1}} : f_rfull[RWID-1:0];

   logic                 out_valid_ff;
   logic [CW-1:0]        out_c_ff [3];
   logic [RWID-1:0]      out_r_ff;
   logic                 out_enc_ff, out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            out_c_ff[k] <= f_cont ? (f_pick ? f_c1[k] : f_c2[k]) : cen_sat[k];
         end
         out_r_ff   <= f_cont ? (f_pick ? f_r1 : f_r2) : rad_sat;
         out_enc_ff <= f_cont;
         out_sat_ff <= !f_cont && ((|cen_clip) || rad_clip);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSPW'({out_r_ff, out_c_ff[2], out_c_ff[1], out_c_ff[0]});
   assign rsp_tuser  = {out_sat_ff, out_enc_ff};

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("enclosed and saturated both set");

   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

### sv/tsbs_sqrt.sv
// ----------------------------------------------------------------------------
// tsbs_sqrt
// Pipelined integer square root, one root bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module tsbs_sqrt #(
   parameter int RTW = 34,
   parameter int SBW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsbs_pkg::pipe_ctl_type    ctl,
   input  logic [2*RTW-1:0]          radicand,
   input  logic [SBW-1:0]            side_in,
   output logic                      valid_out,
   output logic [RTW-1:0]            root_out,
   output logic [SBW-1:0]            side_out
);

   localparam int SQW = 2 * RTW;
   localparam int RMW = RTW + 4;

   logic [RMW-1:0] rem_ff  [1:RTW];
   logic [RTW-1:0] root_ff [1:RTW];
   logic [SQW-1:0] rad_ff  [1:RTW];
   logic [SBW-1:0] side_ff [1:RTW];
   logic           vld_ff  [1:RTW];

   for (genvar j = 0; j < RTW; j++) begin : g_stage
      logic [RMW-1:0] src_rem;
      logic [RTW-1:0] src_root;
      logic [SQW-1:0] src_rad;
      logic [SBW-1:0] src_side;
      logic           src_vld;
      logic [RMW-1:0] cur;
      logic [RMW-1:0] trial;
      logic           take;
      logic [RMW-1:0] rem_in;
      logic [RTW-1:0] root_in;

      if (j == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rad  = radicand;
         assign src_side = side_in;
         assign src_vld  = ctl.valid;
      end else begin : g_next
         assign src_rem  = rem_ff[j];
         assign src_root = root_ff[j];
         assign src_rad  = rad_ff[j];
         assign src_side = side_ff[j];
         assign src_vld  = vld_ff[j];
      end

      assign cur     = {src_rem[RMW-3:0], src_rad[SQW-1 -: 2]};
      assign trial   = {2'b00, src_root, 2'b01};
      assign take    = (cur >= trial);
      assign rem_in  = take ? (cur - trial) : cur;
      assign root_in = {src_root[RTW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff[j+1] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
            rad_ff[j+1]  <= {src_rad[SQW-3:0], 2'b00};
            side_ff[j+1] <= src_side;
         end
      end
   end

   assign valid_out = vld_ff[RTW];
   assign root_out  = root_ff[RTW];
   assign side_out  = side_ff[RTW];

endmodule

### sv/tsbs_div.sv
// ----------------------------------------------------------------------------
// tsbs_div
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage; the quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module tsbs_div #(
   parameter int DVW = 34,
   parameter int QW  = 33,
   parameter int SBW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsbs_pkg::pipe_ctl_type    ctl,
   input  logic [DVW+QW-1:0]         numer [3],
   input  logic [DVW-1:0]            divisor,
   input  logic [SBW-1:0]            side_in,
   output logic                      valid_out,
   output logic [QW-1:0]             quot_out [3],
   output logic [SBW-1:0]            side_out
);

   logic [DVW-1:0] rem_ff  [1:QW][3];
   logic [QW-1:0]  low_ff  [1:QW][3];
   logic [DVW-1:0] dvs_ff  [1:QW];
   logic [SBW-1:0] side_ff [1:QW];
   logic           vld_ff  [1:QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic [DVW-1:0] src_rem [3];
      logic [QW-1:0]  src_low [3];
      logic [DVW-1:0] src_dvs;
      logic [SBW-1:0] src_side;
      logic           src_vld;
      logic [DVW-1:0] rem_in [3];
      logic [QW-1:0]  low_in [3];

      if (j == 0) begin : g_first
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign src_rem[k] = numer[k][DVW+QW-1:QW];
            assign src_low[k] = numer[k][QW-1:0];
         end
         assign src_dvs  = divisor;
         assign src_side = side_in;
         assign src_vld  = ctl.valid;
      end else begin : g_next
         for (genvar k = 0; k < 3; k++) begin : g_lane
            assign src_rem[k] = rem_ff[j][k];
            assign src_low[k] = low_ff[j][k];
         end
         assign src_dvs  = dvs_ff[j];
         assign src_side = side_ff[j];
         assign src_vld  = vld_ff[j];
      end

      for (genvar k = 0; k < 3; k++) begin : g_calc
         logic [DVW:0] cur;
         logic         take;
         assign cur       = {src_rem[k], src_low[k][QW-1]};
         assign take      = (cur >= {1'b0, src_dvs});
         assign rem_in[k] = take ? DVW'(cur - {1'b0, src_dvs}) : cur[DVW-1:0];
         // quotient bits shift in from the bottom as numerator bits leave the top
         assign low_in[k] = {src_low[k][QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff[j+1] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            for (int k = 0; k < 3; k++) begin
               rem_ff[j+1][k] <= rem_in[k];
               low_ff[j+1][k] <= low_in[k];
            end
            dvs_ff[j+1]  <= src_dvs;
            side_ff[j+1] <= src_side;
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_out
      assign quot_out[k] = low_ff[QW][k];
   end
   assign valid_out = vld_ff[QW];
   assign side_out  = side_ff[QW];

endmodule
